// ----- rtl/core/tccs_pkg.sv -----
// tccs_pkg: shared widths, constants, status codes and the arctan table
// for the tilt-compensated compass pipeline; depends on nothing
package tccs_pkg;

  localparam int RAW_W      = 16;
  localparam int WIDE_W     = 24;
  localparam int CFG_W      = 7;
  localparam int Q15_W      = 16;
  localparam int RATIO_W    = 31;
  localparam int SQRT_STEPS = 16;
  localparam int ANG_W      = 26;
  localparam int ATAN_LEN   = 24;

  localparam logic [CFG_W-1:0]   TILT_RESET = 7'd40;
  localparam logic [Q15_W-1:0]   Q15_MAX    = 16'd32767;
  localparam logic [RATIO_W-1:0] Q30_ONE    = 31'h4000_0000;

  localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] FULL_TURN = 26'sd23592960;

  localparam int HEAD_WRAP = 3600;
  localparam int SECT_LO   = 250;
  localparam int SECT_HI   = 3400;
  localparam int SECT_STEP = 450;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TILT = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    case (i)
      0:  return 26'sd2949120;
      1:  return 26'sd1740967;
      2:  return 26'sd919879;
      3:  return 26'sd466945;
      4:  return 26'sd234379;
      5:  return 26'sd117304;
      6:  return 26'sd58666;
      7:  return 26'sd29335;
      8:  return 26'sd14668;
      9:  return 26'sd7334;
      10: return 26'sd3667;
      11: return 26'sd1833;
      12: return 26'sd917;
      13: return 26'sd458;
      14: return 26'sd229;
      15: return 26'sd115;
      16: return 26'sd57;
      17: return 26'sd29;
      18: return 26'sd14;
      19: return 26'sd7;
      20: return 26'sd4;
      21: return 26'sd2;
      22: return 26'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- rtl/core/tccs_in_if.sv -----
// tccs_in_if: sensor sample channel, valid/ready with six raw axes
// depends on tccs_pkg
interface tccs_in_if;
  logic valid;
  logic ready;
  logic signed [tccs_pkg::RAW_W-1:0] acc_x;
  logic signed [tccs_pkg::RAW_W-1:0] acc_y;
  logic signed [tccs_pkg::RAW_W-1:0] acc_z;
  logic signed [tccs_pkg::RAW_W-1:0] mag_x;
  logic signed [tccs_pkg::RAW_W-1:0] mag_y;
  logic signed [tccs_pkg::RAW_W-1:0] mag_z;

  modport source(output valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, input ready);
  modport sink(input valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, output ready);
endinterface

// ----- rtl/core/tccs_out_if.sv -----
// tccs_out_if: heading result channel, valid/ready with heading, sector, status
// depends on nothing
interface tccs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] heading_tenths;
  logic [2:0]  sector;
  logic [1:0]  status;

  modport source(output valid, heading_tenths, sector, status, input ready);
  modport sink(input valid, heading_tenths, sector, status, output ready);
endinterface

// ----- rtl/core/tccs_div.sv -----
// tccs_div: pipelined restoring divider, floor(num * 2^30 / den), one bit per stage
// depends on tccs_pkg
module tccs_div #(
  parameter int NW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [NW-1:0]     num_i,
  input  logic [NW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [tccs_pkg::RATIO_W-1:0] q_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STG = tccs_pkg::RATIO_W;
  localparam int QW  = tccs_pkg::RATIO_W;

  logic [NW:0]       rem_r  [STG];
  logic [NW-1:0]     den_r  [STG];
  logic [QW-1:0]     q_r    [STG];
  logic [SIDE_W-1:0] side_r [STG];
  logic [STG-1:0]    vld_r;

  for (genvar k = 0; k < STG; k++) begin : g_stg
    logic [NW:0]       cur;
    logic [NW-1:0]     dc;
    logic [QW-1:0]     qc;
    logic [SIDE_W-1:0] sc;
    logic              vc;
    logic [NW:0]       rem_nxt;
    logic [QW-1:0]     q_nxt;

    if (k == 0) begin : g_first
      assign cur = {1'b0, num_i};
      assign dc  = den_i;
      assign qc  = '0;
      assign sc  = side_i;
      assign vc  = vld_i;
    end else begin : g_next
      assign cur = {rem_r[k-1][NW-1:0], 1'b0};
      assign dc  = den_r[k-1];
      assign qc  = {q_r[k-1][QW-2:0], 1'b0};
      assign sc  = side_r[k-1];
      assign vc  = vld_r[k-1];
    end

    always_comb begin
      if (cur >= {1'b0, dc}) begin
        rem_nxt = cur - {1'b0, dc};
        q_nxt   = qc | {{(QW-1){1'b0}}, 1'b1};
      end else begin
        rem_nxt = cur;
        q_nxt   = qc;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= dc;
        q_r[k]    <= q_nxt;
        side_r[k] <= sc;
      end
    end
  end

  assign vld_o  = vld_r[STG-1];
  assign q_o    = q_r[STG-1];
  assign side_o = side_r[STG-1];

endmodule

// ----- rtl/core/tccs_sqrt.sv -----
// tccs_sqrt: pipelined integer square root of a value up to 2^30, two bits per stage,
// result saturated to the q1.15 maximum; depends on tccs_pkg
module tccs_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [tccs_pkg::RATIO_W-1:0] v_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [tccs_pkg::Q15_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STG = tccs_pkg::SQRT_STEPS;
  localparam int VW  = tccs_pkg::RATIO_W;
  localparam int RW  = VW + 1;

  logic [VW-1:0]     val_r  [STG];
  logic [RW-1:0]     res_r  [STG];
  logic [SIDE_W-1:0] side_r [STG];
  logic [STG-1:0]    vld_r;

  for (genvar k = 0; k < STG; k++) begin : g_stg
    localparam logic [RW-1:0] BIT = RW'(1) << (VW - 1 - 2 * k);
    logic [VW-1:0]     vc;
    logic [RW-1:0]     rc;
    logic [SIDE_W-1:0] sc;
    logic              vldc;
    logic [RW-1:0]     trial;
    logic [VW-1:0]     val_nxt;
    logic [RW-1:0]     res_nxt;

    if (k == 0) begin : g_first
      assign vc   = v_i;
      assign rc   = '0;
      assign sc   = side_i;
      assign vldc = vld_i;
    end else begin : g_next
      assign vc   = val_r[k-1];
      assign rc   = res_r[k-1];
      assign sc   = side_r[k-1];
      assign vldc = vld_r[k-1];
    end

    always_comb begin
      trial = rc + BIT;
      if ({1'b0, vc} >= trial) begin
        val_nxt = vc - trial[VW-1:0];
        res_nxt = (rc >> 1) + BIT;
      end else begin
        val_nxt = vc;
        res_nxt = rc >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vldc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= val_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= sc;
      end
    end
  end

  assign vld_o  = vld_r[STG-1];
  assign side_o = side_r[STG-1];
  assign root_o = (res_r[STG-1] > RW'(tccs_pkg::Q15_MAX)) ? tccs_pkg::Q15_MAX
                                                          : res_r[STG-1][tccs_pkg::Q15_W-1:0];

endmodule

// ----- rtl/core/tccs_cordic.sv -----
// tccs_cordic: pipelined vectoring cordic, atan2(y, x) in 1/65536 degree,
// one pre-rotation stage then one stage per micro-rotation; depends on tccs_pkg
module tccs_cordic #(
  parameter int XW     = 17,
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic signed [tccs_pkg::ANG_W-1:0] z_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int IW = XW + 2;
  localparam int AW = tccs_pkg::ANG_W;
  localparam int NS = (STEPS > tccs_pkg::ATAN_LEN) ? tccs_pkg::ATAN_LEN : STEPS;

  logic signed [IW-1:0] x_r    [NS+1];
  logic signed [IW-1:0] y_r    [NS+1];
  logic signed [AW-1:0] z_r    [NS+1];
  logic [SIDE_W-1:0]    side_r [NS+1];
  logic [NS:0]          zero_r;
  logic [NS:0]          vld_r;

  logic signed [IW-1:0] x0_nxt;
  logic signed [IW-1:0] y0_nxt;
  logic signed [AW-1:0] z0_nxt;

  // fold the left half-plane onto the right
  always_comb begin
    x0_nxt = IW'(x_i);
    y0_nxt = IW'(y_i);
    z0_nxt = '0;
    if (x_i < 0) begin
      z0_nxt = (y_i >= 0) ? tccs_pkg::HALF_TURN : -tccs_pkg::HALF_TURN;
      x0_nxt = -IW'(x_i);
      y0_nxt = -IW'(y_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      zero_r[0] <= (x_i == 0) && (y_i == 0);
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stg
    logic signed [IW-1:0] xs;
    logic signed [IW-1:0] ys;
    logic signed [IW-1:0] x_nxt;
    logic signed [IW-1:0] y_nxt;
    logic signed [AW-1:0] z_nxt;

    always_comb begin
      xs = x_r[k-1] >>> (k - 1);
      ys = y_r[k-1] >>> (k - 1);
      if (y_r[k-1] > 0) begin
        x_nxt = x_r[k-1] + ys;
        y_nxt = y_r[k-1] - xs;
        z_nxt = z_r[k-1] + tccs_pkg::atan_entry(k - 1);
      end else begin
        x_nxt = x_r[k-1] - ys;
        y_nxt = y_r[k-1] + xs;
        z_nxt = z_r[k-1] - tccs_pkg::atan_entry(k - 1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        zero_r[k] <= zero_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign vld_o  = vld_r[NS];
  assign side_o = side_r[NS];
  assign z_o    = zero_r[NS] ? '0 : z_r[NS];

endmodule

// ----- rtl/core/tilt_compensated_compass_sector.sv -----
// Tilt-compensated compass: one accelerometer and magnetometer triple in, one heading
// in tenths of a degree, a 45-degree sector and a tilt status out. The pipeline takes
// a transaction in every cycle while the result channel does not stall, and each result
// passes through the 31-stage divider for the tilt sines, the two 16-stage square roots
// for sine and cosine, and the CORDIC stages. While the result channel stalls with a
// result held, the whole pipeline holds. max_tilt_deg is written through cfg_we/cfg_wdata
// and resets to 40.
module tilt_compensated_compass_sector #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tccs_pkg::CFG_W-1:0] cfg_wdata,
  tccs_in_if.sink                    in_ch,
  tccs_out_if.source                 out_ch
);

  localparam int SB   = SAMPLE_BITS;
  localparam int SQ_W = 2 * SB;
  localparam int HW   = SB + 33;
  localparam int P1W  = SB + 17;
  localparam int P2W  = SB + 18;
  localparam int QW   = tccs_pkg::Q15_W;
  localparam int AW   = tccs_pkg::ANG_W;
  localparam int WW   = tccs_pkg::WIDE_W;
  localparam int RW   = tccs_pkg::RAW_W;

  typedef struct packed {
    logic                 zero;
    logic                 neg;
    logic signed [SB-1:0] mx;
    logic signed [SB-1:0] my;
    logic signed [SB-1:0] mz;
  } mag_side_t;

  typedef struct packed {
    logic                 zero;
    logic signed [QW-1:0] sp;
    logic signed [SB-1:0] mx;
    logic signed [SB-1:0] my;
    logic signed [SB-1:0] mz;
  } trig_side_t;

  function automatic logic signed [SB-1:0] samp(input logic signed [RW-1:0] f);
    logic [WW-1:0] e;
    e = {{(WW-RW){1'b0}}, f};
    return signed'(e[SB-1:0]);
  endfunction

  logic adv;
  logic [tccs_pkg::CFG_W-1:0] max_tilt_r;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tilt_r <= tccs_pkg::TILT_RESET;
    end else if (cfg_we) begin
      max_tilt_r <= cfg_wdata;
    end
  end

  // stage 1: sample extraction and squares
  logic signed [SB-1:0]   ax_nxt, ay_nxt, az_nxt;
  logic signed [SQ_W-1:0] axp_nxt, ayp_nxt, azp_nxt;
  logic                   v1_r, zero1_r;
  logic signed [SB-1:0]   ax_r, ay_r, mx_r, my_r, mz_r;
  logic [SQ_W-1:0]        axsq_r, aysq_r, azsq_r;

  always_comb begin
    ax_nxt  = samp(in_ch.acc_x);
    ay_nxt  = samp(in_ch.acc_y);
    az_nxt  = samp(in_ch.acc_z);
    axp_nxt = ax_nxt * ax_nxt;
    ayp_nxt = ay_nxt * ay_nxt;
    azp_nxt = az_nxt * az_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      mx_r    <= samp(in_ch.mag_x);
      my_r    <= samp(in_ch.mag_y);
      mz_r    <= samp(in_ch.mag_z);
      axsq_r  <= $unsigned(axp_nxt);
      aysq_r  <= $unsigned(ayp_nxt);
      azsq_r  <= $unsigned(azp_nxt);
      zero1_r <= (ax_nxt == 0) && (ay_nxt == 0) && (az_nxt == 0);
    end
  end

  // stage 2: squared length
  logic            v2_r, ayneg2_r;
  logic [SQ_W-1:0] n2_r, numx_r, numy_r;
  mag_side_t       side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_r     <= axsq_r + aysq_r + azsq_r;
      numx_r   <= axsq_r;
      numy_r   <= aysq_r;
      ayneg2_r <= ay_r < 0;
      side2_r  <= '{zero: zero1_r, neg: (ax_r < 0), mx: mx_r, my: my_r, mz: mz_r};
    end
  end

  // sine magnitudes: ratio then root
  logic                        dvx_vld, dvy_vld, dvy_neg;
  logic [tccs_pkg::RATIO_W-1:0] qx, qy;
  mag_side_t                   dvx_side;

  tccs_div #(.NW(SQ_W), .SIDE_W($bits(mag_side_t))) u_div_x (
    .clk, .rst_n, .en(adv), .vld_i(v2_r), .num_i(numx_r), .den_i(n2_r),
    .side_i(side2_r), .vld_o(dvx_vld), .q_o(qx), .side_o(dvx_side)
  );

  tccs_div #(.NW(SQ_W), .SIDE_W(1)) u_div_y (
    .clk, .rst_n, .en(adv), .vld_i(v2_r), .num_i(numy_r), .den_i(n2_r),
    .side_i(ayneg2_r), .vld_o(dvy_vld), .q_o(qy), .side_o(dvy_neg)
  );

  logic          sqx_vld, sqy_vld, sqy_neg;
  logic [QW-1:0] sx, sy;
  mag_side_t     sqx_side;

  tccs_sqrt #(.SIDE_W($bits(mag_side_t))) u_sqrt_x (
    .clk, .rst_n, .en(adv), .vld_i(dvx_vld), .v_i(qx), .side_i(dvx_side),
    .vld_o(sqx_vld), .root_o(sx), .side_o(sqx_side)
  );

  tccs_sqrt #(.SIDE_W(1)) u_sqrt_y (
    .clk, .rst_n, .en(adv), .vld_i(dvy_vld), .v_i(qy), .side_i(dvy_neg),
    .vld_o(sqy_vld), .root_o(sy), .side_o(sqy_neg)
  );

  // stage 3: signed sines and their squares
  logic                 v3_r;
  trig_side_t           t3_r;
  logic signed [QW-1:0] sr3_r;
  logic [2*QW-3:0]      sqp3_r, sqr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= sqx_vld & sqy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_r   <= '{zero: sqx_side.zero,
                  sp: (sqx_side.neg ? -signed'(sx) : signed'(sx)),
                  mx: sqx_side.mx, my: sqx_side.my, mz: sqx_side.mz};
      sr3_r  <= sqy_neg ? signed'(sy) : -signed'(sy);
      sqp3_r <= sx[QW-2:0] * sx[QW-2:0];
      sqr3_r <= sy[QW-2:0] * sy[QW-2:0];
    end
  end

  // cosines
  logic                 cp_vld, cr_vld;
  logic [QW-1:0]        cp, cr;
  trig_side_t           cp_side;
  logic signed [QW-1:0] cr_sr;

  tccs_sqrt #(.SIDE_W($bits(trig_side_t))) u_cos_p (
    .clk, .rst_n, .en(adv), .vld_i(v3_r), .v_i(tccs_pkg::Q30_ONE - {1'b0, sqp3_r}),
    .side_i(t3_r), .vld_o(cp_vld), .root_o(cp), .side_o(cp_side)
  );

  tccs_sqrt #(.SIDE_W(QW)) u_cos_r (
    .clk, .rst_n, .en(adv), .vld_i(v3_r), .v_i(tccs_pkg::Q30_ONE - {1'b0, sqr3_r}),
    .side_i(sr3_r), .vld_o(cr_vld), .root_o(cr), .side_o(cr_sr)
  );

  // stage 6: first products
  logic signed [P1W-1:0] mxcp_nxt, mycr_nxt;
  logic signed [P1W-2:0] mzsp_nxt;
  logic signed [31:0]    srsp_nxt;
  logic signed [32:0]    srcp_nxt;
  logic signed [QW-1:0]  sr_abs_nxt, sp_abs_nxt;

  logic                  v6_r, zero6_r;
  logic signed [SB-1:0]  mx6_r, mz6_r;
  logic signed [P1W-1:0] mxcp6_r, mycr6_r;
  logic signed [P1W-2:0] mzsp6_r;
  logic signed [31:0]    srsp6_r;
  logic signed [32:0]    srcp6_r;
  logic [QW-1:0]         cr6_r, cp6_r, sra6_r, spa6_r;

  always_comb begin
    mxcp_nxt   = cp_side.mx * signed'({1'b0, cp});
    mycr_nxt   = cp_side.my * signed'({1'b0, cr});
    mzsp_nxt   = cp_side.mz * cp_side.sp;
    srsp_nxt   = cr_sr * cp_side.sp;
    srcp_nxt   = cr_sr * signed'({1'b0, cp});
    sr_abs_nxt = (cr_sr < 0) ? -cr_sr : cr_sr;
    sp_abs_nxt = (cp_side.sp < 0) ? -cp_side.sp : cp_side.sp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= cp_vld & cr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero6_r <= cp_side.zero;
      mx6_r   <= cp_side.mx;
      mz6_r   <= cp_side.mz;
      mxcp6_r <= mxcp_nxt;
      mycr6_r <= mycr_nxt;
      mzsp6_r <= mzsp_nxt;
      srsp6_r <= srsp_nxt;
      srcp6_r <= srcp_nxt;
      cr6_r   <= cr;
      cp6_r   <= cp;
      sra6_r  <= $unsigned(sr_abs_nxt);
      spa6_r  <= $unsigned(sp_abs_nxt);
    end
  end

  // stage 7: second products
  logic signed [HW-1:0]  mxsrsp_nxt, mzsrcp_nxt;
  logic                  v7_r, zero7_r;
  logic signed [HW-1:0]  mxsrsp7_r, mzsrcp7_r;
  logic signed [P2W-1:0] hxs7_r;
  logic signed [P1W-1:0] mycr7_r;
  logic [QW-1:0]         cr7_r, cp7_r, sra7_r, spa7_r;

  always_comb begin
    mxsrsp_nxt = mx6_r * srsp6_r;
    mzsrcp_nxt = mz6_r * srcp6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero7_r   <= zero6_r;
      mxsrsp7_r <= mxsrsp_nxt;
      mzsrcp7_r <= mzsrcp_nxt;
      hxs7_r    <= P2W'(mxcp6_r) + P2W'(mzsp6_r);
      mycr7_r   <= mycr6_r;
      cr7_r     <= cr6_r;
      cp7_r     <= cp6_r;
      sra7_r    <= sra6_r;
      spa7_r    <= spa6_r;
    end
  end

  // stage 8: horizontal field components
  logic                 v8_r, zero8_r;
  logic signed [HW-1:0] hx8_r, hy8_r;
  logic [QW-1:0]        cr8_r, cp8_r, sra8_r, spa8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero8_r <= zero7_r;
      hx8_r   <= HW'(hxs7_r) <<< 15;
      hy8_r   <= mxsrsp7_r + (HW'(mycr7_r) <<< 15) - mzsrcp7_r;
      cr8_r   <= cr7_r;
      cp8_r   <= cp7_r;
      sra8_r  <= sra7_r;
      spa8_r  <= spa7_r;
    end
  end

  // angles
  logic                 cm_vld, ctr_vld, ctp_vld;
  logic                 cm_zero, ctr_zero, ctp_zero;
  logic signed [AW-1:0] zm, zr, zp;

  tccs_cordic #(.XW(HW), .STEPS(CORDIC_STEPS), .SIDE_W(1)) u_cordic_head (
    .clk, .rst_n, .en(adv), .vld_i(v8_r), .x_i(hx8_r), .y_i(hy8_r),
    .side_i(zero8_r), .vld_o(cm_vld), .z_o(zm), .side_o(cm_zero)
  );

  tccs_cordic #(.XW(QW+1), .STEPS(CORDIC_STEPS), .SIDE_W(1)) u_cordic_roll (
    .clk, .rst_n, .en(adv), .vld_i(v8_r), .x_i(signed'({1'b0, cr8_r})),
    .y_i(signed'({1'b0, sra8_r})), .side_i(zero8_r), .vld_o(ctr_vld), .z_o(zr),
    .side_o(ctr_zero)
  );

  tccs_cordic #(.XW(QW+1), .STEPS(CORDIC_STEPS), .SIDE_W(1)) u_cordic_pitch (
    .clk, .rst_n, .en(adv), .vld_i(v8_r), .x_i(signed'({1'b0, cp8_r})),
    .y_i(signed'({1'b0, spa8_r})), .side_i(zero8_r), .vld_o(ctp_vld), .z_o(zp),
    .side_o(ctp_zero)
  );

  // stage 9: wrap, scale to tenths, tilt check
  logic signed [AW-1:0] zw_nxt, lim_nxt;
  logic [29:0]          zu_nxt, t_nxt;
  logic                 v9_r, zero9_r, bad9_r;
  logic [12:0]          head9_r;

  always_comb begin
    zw_nxt  = (zm < 0) ? zm + tccs_pkg::FULL_TURN : zm;
    zu_nxt  = 30'($unsigned(zw_nxt));
    t_nxt   = (zu_nxt << 3) + (zu_nxt << 1) + 30'd32768;
    lim_nxt = signed'({{(AW-tccs_pkg::CFG_W-16){1'b0}}, max_tilt_r, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (adv) begin
      v9_r <= cm_vld & ctr_vld & ctp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero9_r <= cm_zero & ctr_zero & ctp_zero;
      head9_r <= t_nxt[28:16];
      bad9_r  <= (zr > lim_nxt) || (zp > lim_nxt);
    end
  end

  // stage 10: output register
  logic [12:0] hw_nxt;
  logic [11:0] head_nxt;
  logic [2:0]  sect_nxt;
  logic        vout_r;
  logic [11:0] head_r;
  logic [2:0]  sect_r;
  logic [1:0]  stat_r;

  always_comb begin
    hw_nxt   = (head9_r >= 13'(tccs_pkg::HEAD_WRAP)) ? head9_r - 13'(tccs_pkg::HEAD_WRAP)
                                                     : head9_r;
    head_nxt = hw_nxt[11:0];
    sect_nxt = '0;
    if (head_nxt >= 12'(tccs_pkg::SECT_LO) && head_nxt < 12'(tccs_pkg::SECT_HI)) begin
      sect_nxt = 3'd1;
      for (int k = 1; k < 7; k++) begin
        if (head_nxt >= 12'(tccs_pkg::SECT_LO + k * tccs_pkg::SECT_STEP)) begin
          sect_nxt = 3'(k + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (adv) begin
      vout_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero9_r) begin
        head_r <= '0;
        sect_r <= '0;
        stat_r <= tccs_pkg::ST_ZERO;
      end else begin
        head_r <= head_nxt;
        sect_r <= sect_nxt;
        stat_r <= bad9_r ? tccs_pkg::ST_TILT : tccs_pkg::ST_OK;
      end
    end
  end

  assign out_ch.valid          = vout_r;
  assign out_ch.heading_tenths = head_r;
  assign out_ch.sector         = sect_r;
  assign out_ch.status         = stat_r;

`ifndef NO_ASSERTIONS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (sqx_vld == sqy_vld) && (cp_vld == cr_vld) && (cm_vld == ctr_vld) && (cm_vld == ctp_vld))
    else $error("parallel lanes out of step");

  a_zero_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cm_vld |-> (cm_zero == ctr_zero) && (cm_zero == ctp_zero))
    else $error("zero flag differs between cordic lanes");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.heading_tenths < 12'(tccs_pkg::HEAD_WRAP)))
    else $error("heading out of range");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

// ----- tb/sv/tilt_compensated_compass_sector_test.sv -----
// tilt_compensated_compass_sector_test: self-checking bench for the compass pipeline
// drives sensor transactions with bursts and stalls, predicts each heading, sector and
// status in a scoreboard class; depends on tccs_pkg, tccs_in_if, tccs_out_if and the rtl
`timescale 1ns / 100ps

module tilt_compensated_compass_sector_test;

  typedef struct {
    logic signed [15:0] ax, ay, az, mx, my, mz;
  } sample_t;

  typedef struct {
    logic [11:0] heading;
    logic [2:0]  sector;
    logic [1:0]  status;
  } heading_t;

  class heading_scoreboard;
    heading_t   pending_q[$];
    logic [6:0] tilt_limit = tccs_pkg::TILT_RESET;
    int         mismatches = 0;

    function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    function automatic longint unsigned frac30(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      if (r >= den) begin
        q = 1;
        r = r - den;
      end
      for (int i = 0; i < 30; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    function automatic longint sine(longint a, longint unsigned n2);
      longint unsigned m, s;
      m = (a < 0) ? -a : a;
      s = isqrt(frac30(m * m, n2));
      if (s > 32767) s = 32767;
      return (a < 0) ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint cosine(longint s);
      longint unsigned c;
      c = isqrt((64'd1 << 30) - longint'(s * s));
      if (c > 32767) c = 32767;
      return longint'(c);
    endfunction

    function automatic longint angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 180 * 65536 : -180 * 65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(tccs_pkg::atan_entry(i));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(tccs_pkg::atan_entry(i));
        end
      end
      return z;
    endfunction

    function automatic heading_t predict(sample_t s);
      heading_t r;
      longint ax, ay, az, mx, my, mz, sr, sp, cr, cp, hx, hy, z, lim, hd;
      longint unsigned n2;
      ax = s.ax; ay = s.ay; az = s.az; mx = s.mx; my = s.my; mz = s.mz;
      if (ax == 0 && ay == 0 && az == 0) begin
        r.heading = '0;
        r.sector = '0;
        r.status = tccs_pkg::ST_ZERO;
        return r;
      end
      n2 = ax * ax + ay * ay + az * az;
      sr = -sine(ay, n2);
      sp = sine(ax, n2);
      cr = cosine(sr);
      cp = cosine(sp);
      hx = (mx * cp + mz * sp) * 32768;
      hy = mx * sr * sp + my * cr * 32768 - mz * sr * cp;
      z = angle(hx, hy);
      while (z < 0) z = z + 360 * 65536;
      hd = ((z * 10 + 32768) >> 16) % tccs_pkg::HEAD_WRAP;
      r.heading = 12'(hd);
      if (hd < tccs_pkg::SECT_LO || hd >= tccs_pkg::SECT_HI) r.sector = '0;
      else r.sector = 3'((hd - tccs_pkg::SECT_LO) / tccs_pkg::SECT_STEP + 1);
      lim = longint'(tilt_limit) * 65536;
      r.status = tccs_pkg::ST_OK;
      if (angle(cr, (sr < 0) ? -sr : sr) > lim || angle(cp, (sp < 0) ? -sp : sp) > lim)
        r.status = tccs_pkg::ST_TILT;
      return r;
    endfunction

    function void note(sample_t s);
      pending_q.push_back(predict(s));
    endfunction

    function void check(heading_t got);
      heading_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result h=%0d s=%0d st=%0d",
                                       got.heading, got.sector, got.status);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.heading !== exp_r.heading || got.sector !== exp_r.sector ||
          got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected h=%0d s=%0d st=%0d, actual h=%0d s=%0d st=%0d",
                   exp_r.heading, exp_r.sector, exp_r.status,
                   got.heading, got.sector, got.status);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       cfg_we = 0;
  logic [6:0] cfg_wdata = '0;
  logic       hold_req = 0;
  int         idle_cycles = 0;
  logic       any_hs = 0;
  int         burst_left = 1;

  tccs_in_if  in_ch();
  tccs_out_if out_ch();

  heading_scoreboard sb = new();

  tilt_compensated_compass_sector dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.acc_x = 0; in_ch.acc_y = 0; in_ch.acc_z = 0;
    in_ch.mag_x = 0; in_ch.mag_y = 0; in_ch.mag_z = 0;
    out_ch.ready = 0;
  end

  // inputs settle between edges, so negedge values are what the next edge takes
  always @(negedge clk) begin
    heading_t got;
    sample_t s;
    any_hs = 0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s.ax = in_ch.acc_x; s.ay = in_ch.acc_y; s.az = in_ch.acc_z;
      s.mx = in_ch.mag_x; s.my = in_ch.mag_y; s.mz = in_ch.mag_z;
      sb.note(s);
      any_hs = 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.heading = out_ch.heading_tenths;
      got.sector = out_ch.sector;
      got.status = out_ch.status;
      sb.check(got);
      any_hs = 1;
    end
  end

  // receiver stall pattern and long hold-off
  initial begin
    int mode, span;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= ($urandom_range(0, 9) < 7);
          2: out_ch.ready <= ($urandom_range(0, 9) < 3);
          default: out_ch.ready <= ((span & 3) != 0);
        endcase
        span--;
      end
    end
  end

  always @(posedge clk) begin
    if (any_hs) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push(input sample_t s);
    logic hs;
    int gap;
    in_ch.valid <= 1;
    in_ch.acc_x <= s.ax; in_ch.acc_y <= s.ay; in_ch.acc_z <= s.az;
    in_ch.mag_x <= s.mx; in_ch.mag_y <= s.my; in_ch.mag_z <= s.mz;
    do begin
      @(negedge clk);
      hs = in_ch.valid && in_ch.ready;
      @(posedge clk);
    end while (!hs);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic set_tilt(input logic [6:0] v);
    in_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.tilt_limit = v;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd1;
      3: return 16'sd1;
      4: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int spread;
    s.mx = 16'($urandom); s.my = 16'($urandom); s.mz = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
      end
      2, 3, 4: begin
        spread = $urandom_range(1, 8000);
        s.ax = 16'($urandom_range(0, 2 * spread) - spread);
        s.ay = 16'($urandom_range(0, 2 * spread) - spread);
        s.az = 16'($urandom_range(8000, 32767));
        if ($urandom_range(0, 1)) s.az = -s.az;
      end
      5, 6: begin
        spread = $urandom_range(1, 30000);
        s.ax = 16'($urandom_range(0, 2 * spread) - spread);
        s.ay = 16'($urandom_range(0, 2 * spread) - spread);
        s.az = 16'($urandom_range(0, 20000) - 10000);
      end
      7: begin
        s.ax = 0; s.ay = 0; s.az = 0;
      end
      default: begin
        s.ax = pick_edge(); s.ay = pick_edge(); s.az = pick_edge();
        s.mx = pick_edge(); s.my = pick_edge(); s.mz = pick_edge();
      end
    endcase
    if ($urandom_range(0, 15) == 0) begin
      s.mx = 0; s.my = 0; s.mz = 0;
    end
    return s;
  endfunction

  initial begin
    sample_t dir_q[$];
    logic [6:0] limits[6];
    limits = '{7'd40, 7'd0, 7'd90, 7'd127, 7'd17, 7'd0};
    limits[5] = 7'($urandom_range(1, 89));

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    dir_q.push_back('{0, 0, 0, 100, 200, 300});
    dir_q.push_back('{0, 0, 0, -32768, 32767, -32768});
    dir_q.push_back('{0, 0, 16384, 1000, 0, 0});
    dir_q.push_back('{0, 0, 16384, 0, 1000, 0});
    dir_q.push_back('{0, 0, 16384, -1000, 0, 0});
    dir_q.push_back('{0, 0, 16384, 0, -1000, 0});
    dir_q.push_back('{0, 0, 16384, 1000, -1000, 0});
    dir_q.push_back('{0, 0, 16384, 0, 0, 0});
    dir_q.push_back('{0, 0, -32768, 0, 0, 5000});
    dir_q.push_back('{32767, 0, 0, 500, 500, 500});
    dir_q.push_back('{-32768, 0, 0, 500, 500, 500});
    dir_q.push_back('{0, 32767, 0, 500, -500, 500});
    dir_q.push_back('{0, -32768, 0, -500, 500, -500});
    dir_q.push_back('{-32768, -32768, -32768, -32768, -32768, -32768});
    dir_q.push_back('{32767, 32767, 32767, 32767, 32767, 32767});
    dir_q.push_back('{10500, 0, 12500, 3000, 2000, -1000});
    dir_q.push_back('{10600, 0, 12500, 3000, 2000, -1000});
    dir_q.push_back('{0, 10500, 12500, -2000, 3000, 1000});
    dir_q.push_back('{1, 0, 0, 7, -7, 7});
    dir_q.push_back('{0, 0, 1, -1, -1, -1});
    dir_q.push_back('{-1, 1, -1, 32767, -32768, 0});

    for (int p = 0; p < 6; p++) begin
      set_tilt(limits[p]);
      if (p == 0 || p == 3) foreach (dir_q[i]) push(dir_q[i]);
      if (p == 2) hold_req = 1;
      repeat (225) push(random_sample());
    end
    in_ch.valid <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
